/* hdl/bcse_pkg.sv */
// ----------------------------------------------------------------------------
// bcse_pkg
// Types, constants and the voltage table of the charge state estimator.
// ----------------------------------------------------------------------------
package bcse_pkg;

    localparam int OCV_ENTRIES = 19;

    localparam logic [21:0] UNITS_PER_MAH   = 22'd3600000;
    localparam logic [38:0] RST_FULL_UNITS  = 39'd72000000000;
    localparam logic [40:0] RST_HALF_UNITS  = 41'd36000000000;
    localparam logic [15:0] RST_NOMINAL     = 16'd20000;
    localparam logic [14:0] RST_IDLE_MA     = 15'd50;
    localparam logic [15:0] RST_IDLE_MS     = 16'd30000;
    localparam logic [14:0] RST_FULL_MA     = 15'd200;
    localparam logic [12:0] RST_FULL_MV     = 13'd4150;
    localparam logic [12:0] RST_EMPTY_MV    = 13'd2800;
    localparam logic [11:0] RST_SAVE_S      = 12'd60;
    localparam logic [6:0]  PCT_FULL        = 7'd100;

    localparam logic [2:0] CFG_NOMINAL  = 3'd0;
    localparam logic [2:0] CFG_IDLE_MA  = 3'd1;
    localparam logic [2:0] CFG_IDLE_MS  = 3'd2;
    localparam logic [2:0] CFG_FULL_MA  = 3'd3;
    localparam logic [2:0] CFG_FULL_MV  = 3'd4;
    localparam logic [2:0] CFG_EMPTY_MV = 3'd5;
    localparam logic [2:0] CFG_SAVE_S   = 3'd6;

    localparam logic [12:0] OCV_MV [OCV_ENTRIES] = '{
        13'd4150, 13'd4100, 13'd4050, 13'd4000, 13'd3950, 13'd3900, 13'd3850,
        13'd3800, 13'd3750, 13'd3700, 13'd3650, 13'd3600, 13'd3500, 13'd3400,
        13'd3300, 13'd3200, 13'd3100, 13'd3000, 13'd2800
    };
    localparam logic [6:0] OCV_PCT [OCV_ENTRIES] = '{
        7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70, 7'd65, 7'd60, 7'd50,
        7'd40, 7'd30, 7'd20, 7'd15, 7'd10, 7'd5, 7'd3, 7'd1, 7'd0
    };

    typedef struct packed {
        logic signed [15:0] pack_ma;
        logic [12:0]        cell_mv;
        logic               charger_on;
        logic [15:0]        elapsed_ms;
    } t_in;

    typedef struct packed {
        logic [6:0]  charge_pct;
        logic [6:0]  health_pct;
        logic [16:0] remaining_mah;
        logic [16:0] full_capacity_mah;
        logic [15:0] cycle_tenths;
        logic        save_request;
    } t_out;

    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [47:0] a;
        logic [39:0] b;
    } t_su_req;

    typedef struct packed {
        logic        done;
        logic [47:0] q;
        logic [39:0] r;
    } t_su_rsp;

    function automatic logic [6:0] ocv_percent(input logic [12:0] mv);
        logic [6:0] p;
        logic       hit;
        p   = '0;
        hit = 1'b0;
        for (int i = 0; i < OCV_ENTRIES; i++) begin
            if (!hit && mv >= OCV_MV[i]) begin
                p   = OCV_PCT[i];
                hit = 1'b1;
            end
        end
        return p;
    endfunction

endpackage

/* hdl/battery_charge_state_estimator.sv */
// ----------------------------------------------------------------------------
// battery_charge_state_estimator
// Coulomb counter with voltage table rest correction, capacity learning,
// cycle counting and save requests.
// ----------------------------------------------------------------------------
//  channel  | valid   | stall   | payload
//  ---------+---------+---------+--------
//  sample   | i_valid | o_stall | i_data
//  result   | o_valid | i_stall | o_data
//  config   | i_cfg_we| -       | i_cfg_idx, i_cfg_data
//
// Samples are taken one at a time: a new sample is accepted only once the
// result of the last one is pushed. Every multiply and divide runs on the
// shared bit-serial unit; which of them run depends on which of charging,
// rest correction, learning and the save check apply. A stalled earlier
// result delays the push. Reset is synchronous; no clearing pass. A
// finished result sits in the output register while the next sample is
// taken; o_stall is high while a sample is in work.
// ----------------------------------------------------------------------------
module battery_charge_state_estimator
    import bcse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out        o_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_NOM   = 5'd1;
    localparam logic [4:0] S_PROD  = 5'd2;
    localparam logic [4:0] S_CYC   = 5'd3;
    localparam logic [4:0] S_REST  = 5'd4;
    localparam logic [4:0] S_TGT   = 5'd5;
    localparam logic [4:0] S_TGT2  = 5'd6;
    localparam logic [4:0] S_ADJ   = 5'd7;
    localparam logic [4:0] S_FULL  = 5'd8;
    localparam logic [4:0] S_LRN   = 5'd9;
    localparam logic [4:0] S_H1    = 5'd10;
    localparam logic [4:0] S_H2    = 5'd11;
    localparam logic [4:0] S_EMPTY = 5'd12;
    localparam logic [4:0] S_SOC1  = 5'd13;
    localparam logic [4:0] S_SOC2  = 5'd14;
    localparam logic [4:0] S_SCHK  = 5'd15;
    localparam logic [4:0] S_SAV   = 5'd16;
    localparam logic [4:0] S_REM   = 5'd17;
    localparam logic [4:0] S_FCM   = 5'd18;
    localparam logic [4:0] S_PUSH  = 5'd19;

    logic [15:0] r_nominal;
    logic [14:0] r_idle_ma;
    logic [15:0] r_idle_ms;
    logic [14:0] r_full_ma;
    logic [12:0] r_full_mv;
    logic [12:0] r_empty_mv;
    logic [11:0] r_save_s;

    logic [4:0]         r_state, n_state;
    logic signed [15:0] r_cur, n_cur;
    logic [12:0]        r_mv, n_mv;
    logic               r_chg, n_chg;
    logic [15:0]        r_dt, n_dt;
    logic [37:0]        r_nom, n_nom;
    logic signed [40:0] r_charge, n_charge;
    logic [38:0]        r_fc, n_fc;
    logic [38:0]        r_cis, n_cis;
    logic [15:0]        r_cycle, n_cycle;
    logic [16:0]        r_rest, n_rest;
    logic               r_armed, n_armed;
    logic [21:0]        r_stimer, n_stimer;
    logic [38:0]        r_last, n_last;
    logic [6:0]         r_health, n_health;
    logic [6:0]         r_soc, n_soc;
    logic [16:0]        r_rem, n_rem;
    logic [16:0]        r_fcm, n_fcm;
    logic               r_save, n_save;
    logic               r_neg, n_neg;
    logic               r_o_valid, n_o_valid;
    t_out               r_o_data, n_o_data;

    t_su_req su_req;
    t_su_rsp su_rsp;

    logic               accept;
    logic [15:0]        mag;
    logic [15:0]        nom_mah;
    logic signed [41:0] tdiff;
    logic [40:0]        tmag;
    logic [40:0]        learn2;
    logic [39:0]        nom3;
    logic               learn_ok;
    logic               full_hit;
    logic signed [40:0] c0;
    logic [40:0]        clamped;
    logic [16:0]        rest_sum;
    logic [21:0]        st_sum;
    logic [21:0]        save_lim;
    logic signed [40:0] sdiff;
    logic [39:0]        sabs;

    bcse_serial u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (su_req),
        .o_rsp   (su_rsp)
    );

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

    assign mag      = r_cur[15] ? 16'(-r_cur) : r_cur;
    assign nom_mah  = (r_nominal == '0) ? 16'd1 : r_nominal;
    assign tdiff    = $signed({3'b000, su_rsp.q[38:0]}) - 42'(r_charge);
    assign tmag     = tdiff[41] ? 41'(-tdiff) : tdiff[40:0];
    assign learn2   = {r_charge[39:0], 1'b0};
    assign nom3     = {1'b0, r_nom, 1'b0} + {2'b00, r_nom};
    assign learn_ok = !r_charge[40] && (learn2 > {3'b000, r_nom}) &&
                      (learn2 < {1'b0, nom3});
    assign full_hit = r_chg && r_cur[15] && (mag < {1'b0, r_full_ma}) &&
                      (r_mv >= r_full_mv);
    assign c0       = ((r_mv <= r_empty_mv) && (r_mv != '0)) ? '0 : r_charge;
    assign clamped  = c0[40] ? '0 :
                      (c0[39:0] > {1'b0, r_fc}) ? {2'b00, r_fc} : c0;
    assign rest_sum = r_rest + {1'b0, r_dt};
    assign st_sum   = r_stimer + {6'd0, r_dt};
    assign save_lim = {r_save_s, 10'd0} - {6'd0, r_save_s, 4'd0} -
                      {7'd0, r_save_s, 3'd0};
    assign sdiff    = r_charge - $signed({2'b00, r_last});
    assign sabs     = sdiff[40] ? 40'(-sdiff) : sdiff[39:0];

    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_mv      = r_mv;
        n_chg     = r_chg;
        n_dt      = r_dt;
        n_nom     = r_nom;
        n_charge  = r_charge;
        n_fc      = r_fc;
        n_cis     = r_cis;
        n_cycle   = r_cycle;
        n_rest    = r_rest;
        n_armed   = r_armed;
        n_stimer  = r_stimer;
        n_last    = r_last;
        n_health  = r_health;
        n_soc     = r_soc;
        n_rem     = r_rem;
        n_fcm     = r_fcm;
        n_save    = r_save;
        n_neg     = r_neg;
        n_o_valid = r_o_valid && i_stall;
        n_o_data  = r_o_data;
        su_req    = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cur     = i_data.pack_ma;
                    n_mv      = i_data.cell_mv;
                    n_chg     = i_data.charger_on;
                    n_dt      = i_data.elapsed_ms;
                    su_req    = '{1'b1, 1'b0, {26'd0, UNITS_PER_MAH},
                                  {24'd0, nom_mah}};
                    n_state   = S_NOM;
                end
            end
            S_NOM: begin
                if (su_rsp.done) begin
                    n_nom   = su_rsp.q[37:0];
                    su_req  = '{1'b1, 1'b0, {32'd0, mag}, {24'd0, r_dt}};
                    n_state = S_PROD;
                end
            end
            S_PROD: begin
                if (su_rsp.done) begin
                    if (r_cur[15]) begin
                        n_charge = r_charge + $signed({9'd0, su_rsp.q[31:0]});
                        n_cis    = r_cis + {7'd0, su_rsp.q[31:0]};
                        su_req   = '{1'b1, 1'b1, {9'd0, n_cis}, {2'b00, r_nom}};
                        n_state  = S_CYC;
                    end else begin
                        n_charge = r_charge - $signed({9'd0, su_rsp.q[31:0]});
                        n_state  = S_REST;
                    end
                end
            end
            S_CYC: begin
                if (su_rsp.done) begin
                    n_cis   = su_rsp.r[38:0];
                    n_cycle = r_cycle + {su_rsp.q[12:0], 3'b000} +
                              {su_rsp.q[14:0], 1'b0};
                    n_state = S_REST;
                end
            end
            S_REST: begin
                if (mag < {1'b0, r_idle_ma}) begin
                    if (rest_sum >= {1'b0, r_idle_ms}) begin
                        n_rest  = {1'b0, r_idle_ms};
                        su_req  = '{1'b1, 1'b0, {9'd0, r_fc},
                                    {33'd0, ocv_percent(r_mv)}};
                        n_state = S_TGT;
                    end else begin
                        n_rest  = rest_sum;
                        n_state = S_FULL;
                    end
                end else begin
                    n_rest  = '0;
                    n_state = S_FULL;
                end
            end
            S_TGT: begin
                if (su_rsp.done) begin
                    su_req  = '{1'b1, 1'b1, su_rsp.q, {33'd0, PCT_FULL}};
                    n_state = S_TGT2;
                end
            end
            S_TGT2: begin
                if (su_rsp.done) begin
                    n_neg   = tdiff[41];
                    su_req  = '{1'b1, 1'b1, {7'd0, tmag}, 40'd10};
                    n_state = S_ADJ;
                end
            end
            S_ADJ: begin
                if (su_rsp.done) begin
                    n_charge = r_neg ? r_charge - $signed(su_rsp.q[40:0])
                                     : r_charge + $signed(su_rsp.q[40:0]);
                    n_state  = S_FULL;
                end
            end
            S_FULL: begin
                if (full_hit && r_armed && learn_ok) begin
                    su_req  = '{1'b1, 1'b1,
                                {7'd0, r_fc, 2'b00} + {7'd0, r_charge}, 40'd5};
                    n_state = S_LRN;
                end else begin
                    if (full_hit) begin
                        n_armed  = 1'b0;
                        n_charge = $signed({2'b00, r_fc});
                    end
                    n_state = S_EMPTY;
                end
            end
            S_LRN: begin
                if (su_rsp.done) begin
                    n_fc    = su_rsp.q[38:0];
                    su_req  = '{1'b1, 1'b0, {9'd0, su_rsp.q[38:0]}, 40'd200};
                    n_state = S_H1;
                end
            end
            S_H1: begin
                if (su_rsp.done) begin
                    su_req  = '{1'b1, 1'b1, su_rsp.q + {10'd0, r_nom},
                                {1'b0, r_nom, 1'b0}};
                    n_state = S_H2;
                end
            end
            S_H2: begin
                if (su_rsp.done) begin
                    n_health = (su_rsp.q > {41'd0, PCT_FULL}) ? PCT_FULL
                                                              : su_rsp.q[6:0];
                    n_armed  = 1'b0;
                    n_charge = $signed({2'b00, r_fc});
                    n_state  = S_EMPTY;
                end
            end
            S_EMPTY: begin
                if ((r_mv <= r_empty_mv) && (r_mv != '0)) begin
                    n_armed = 1'b1;
                end
                n_charge = $signed(clamped);
                su_req   = '{1'b1, 1'b0, {7'd0, clamped}, 40'd200};
                n_state  = S_SOC1;
            end
            S_SOC1: begin
                if (su_rsp.done) begin
                    su_req  = '{1'b1, 1'b1, su_rsp.q + {9'd0, r_fc},
                                {r_fc, 1'b0}};
                    n_state = S_SOC2;
                end
            end
            S_SOC2: begin
                if (su_rsp.done) begin
                    if (r_fc == '0) begin
                        n_soc = '0;
                    end else if (su_rsp.q > {41'd0, PCT_FULL}) begin
                        n_soc = PCT_FULL;
                    end else begin
                        n_soc = su_rsp.q[6:0];
                    end
                    n_state = S_SCHK;
                end
            end
            S_SCHK: begin
                n_save = 1'b0;
                if (st_sum >= save_lim) begin
                    n_stimer = '0;
                    su_req   = '{1'b1, 1'b0, {8'd0, sabs}, 40'd100};
                    n_state  = S_SAV;
                end else begin
                    n_stimer = st_sum;
                    su_req   = '{1'b1, 1'b1, {7'd0, r_charge},
                                 {18'd0, UNITS_PER_MAH}};
                    n_state  = S_REM;
                end
            end
            S_SAV: begin
                if (su_rsp.done) begin
                    if (su_rsp.q >= {9'd0, r_fc}) begin
                        n_save = 1'b1;
                        n_last = r_charge[38:0];
                    end
                    su_req  = '{1'b1, 1'b1, {7'd0, r_charge},
                                {18'd0, UNITS_PER_MAH}};
                    n_state = S_REM;
                end
            end
            S_REM: begin
                if (su_rsp.done) begin
                    n_rem   = su_rsp.q[16:0];
                    su_req  = '{1'b1, 1'b1, {9'd0, r_fc}, {18'd0, UNITS_PER_MAH}};
                    n_state = S_FCM;
                end
            end
            S_FCM: begin
                if (su_rsp.done) begin
                    n_fcm   = su_rsp.q[16:0];
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!r_o_valid || !i_stall) begin
                    n_o_valid                  = 1'b1;
                    n_o_data.charge_pct        = r_soc;
                    n_o_data.health_pct        = r_health;
                    n_o_data.remaining_mah     = r_rem;
                    n_o_data.full_capacity_mah = r_fcm;
                    n_o_data.cycle_tenths      = r_cycle;
                    n_o_data.save_request      = r_save;
                    n_state                    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_o_valid  <= 1'b0;
            r_charge   <= $signed(RST_HALF_UNITS);
            r_fc       <= RST_FULL_UNITS;
            r_cis      <= '0;
            r_cycle    <= '0;
            r_rest     <= '0;
            r_armed    <= 1'b0;
            r_stimer   <= '0;
            r_last     <= RST_HALF_UNITS[38:0];
            r_health   <= PCT_FULL;
            r_nominal  <= RST_NOMINAL;
            r_idle_ma  <= RST_IDLE_MA;
            r_idle_ms  <= RST_IDLE_MS;
            r_full_ma  <= RST_FULL_MA;
            r_full_mv  <= RST_FULL_MV;
            r_empty_mv <= RST_EMPTY_MV;
            r_save_s   <= RST_SAVE_S;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_charge  <= n_charge;
            r_fc      <= n_fc;
            r_cis     <= n_cis;
            r_cycle   <= n_cycle;
            r_rest    <= n_rest;
            r_armed   <= n_armed;
            r_stimer  <= n_stimer;
            r_last    <= n_last;
            r_health  <= n_health;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NOMINAL:  r_nominal  <= i_cfg_data;
                    CFG_IDLE_MA:  r_idle_ma  <= i_cfg_data[14:0];
                    CFG_IDLE_MS:  r_idle_ms  <= i_cfg_data;
                    CFG_FULL_MA:  r_full_ma  <= i_cfg_data[14:0];
                    CFG_FULL_MV:  r_full_mv  <= i_cfg_data[12:0];
                    CFG_EMPTY_MV: r_empty_mv <= i_cfg_data[12:0];
                    CFG_SAVE_S:   r_save_s   <= i_cfg_data[11:0];
                    default: begin
                    end
                endcase
            end
        end
        r_cur    <= n_cur;
        r_mv     <= n_mv;
        r_chg    <= n_chg;
        r_dt     <= n_dt;
        r_nom    <= n_nom;
        r_soc    <= n_soc;
        r_rem    <= n_rem;
        r_fcm    <= n_fcm;
        r_save   <= n_save;
        r_neg    <= n_neg;
        r_o_data <= n_o_data;
    end

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_stall)
        else $error("sample accepted but block not busy");

    a_charge_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_charge[40] && r_charge[39:0] <= {1'b0, r_fc}))
        else $error("charge outside zero to full capacity between samples");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.charge_pct <= PCT_FULL && o_data.health_pct <= PCT_FULL))
        else $error("percent above full scale");

    a_push_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH && o_valid && i_stall) |=> (r_state == S_PUSH))
        else $error("result pushed over a pending transaction");
`endif

endmodule

/* hdl/bcse_serial.sv */
// ----------------------------------------------------------------------------
// bcse_serial
// Shared shift-add multiplier (48 x 16) and restoring divider (48 / 40),
// one bit per cycle.
// ----------------------------------------------------------------------------
module bcse_serial
    import bcse_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_su_req i_req,
    output t_su_rsp o_rsp
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic        r_div, n_div;
    logic [5:0]  r_cnt, n_cnt;
    logic [47:0] r_a, n_a;
    logic [39:0] r_b, n_b;
    logic [47:0] r_acc, n_acc;
    logic [40:0] r_rem, n_rem;
    logic [40:0] rem_sh;
    logic [5:0]  last;

    assign rem_sh = {r_rem[39:0], r_a[47]};
    assign last   = r_div ? 6'd47 : 6'd15;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_rem  = r_rem;
        if (r_busy) begin
            n_cnt = r_cnt + 6'd1;
            if (r_div) begin
                if (rem_sh >= {1'b0, r_b}) begin
                    n_rem = rem_sh - {1'b0, r_b};
                    n_a   = {r_a[46:0], 1'b1};
                end else begin
                    n_rem = rem_sh;
                    n_a   = {r_a[46:0], 1'b0};
                end
            end else begin
                if (r_b[0]) begin
                    n_acc = r_acc + r_a;
                end
                n_a = {r_a[46:0], 1'b0};
                n_b = {1'b0, r_b[39:1]};
            end
            if (r_cnt == last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_req.start) begin
            n_busy = 1'b1;
            n_div  = i_req.is_div;
            n_cnt  = '0;
            n_a    = i_req.a;
            n_b    = i_req.b;
            n_acc  = '0;
            n_rem  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_div <= n_div;
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_rem <= n_rem;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_div ? r_a : r_acc;
    assign o_rsp.r    = r_rem[39:0];

endmodule

/* dv/battery_charge_state_estimator_test.sv */
// ----------------------------------------------------------------------------
// battery_charge_state_estimator_test
// Drives current/voltage samples into the charge state estimator, predicts
// charge, capacity learning, cycle count and save requests for each sample,
// and checks every result field. Config is changed between quiet phases.
// ----------------------------------------------------------------------------
import bcse_pkg::*;

class soc_scoreboard;
    longint unsigned nom_mah, idle_ma, idle_ms, full_ma, full_mv, empty_mv, save_s;
    longint charge, cap_units, last_saved;
    longint unsigned chg_in;
    logic [15:0] cycles;
    longint unsigned rest_ms, save_ms;
    bit armed;
    logic [6:0] health;
    t_out pending[$];
    int errors;
    int checked;
    int saves;
    int learns;

    function void reset_state();
        nom_mah = RST_NOMINAL; idle_ma = RST_IDLE_MA; idle_ms = RST_IDLE_MS;
        full_ma = RST_FULL_MA; full_mv = RST_FULL_MV; empty_mv = RST_EMPTY_MV;
        save_s = RST_SAVE_S;
        cap_units = nom_units();
        charge = cap_units / 2;
        last_saved = charge;
        chg_in = 0; cycles = 0; rest_ms = 0; armed = 0; save_ms = 0;
        health = PCT_FULL;
        pending.delete();
    endfunction

    function longint nom_units();
        longint unsigned n;
        n = (nom_mah != 0) ? nom_mah : 1;
        return longint'(n * 3600000);
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] v);
        case (idx)
            CFG_NOMINAL:  nom_mah  = v;
            CFG_IDLE_MA:  idle_ma  = v[14:0];
            CFG_IDLE_MS:  idle_ms  = v;
            CFG_FULL_MA:  full_ma  = v[14:0];
            CFG_FULL_MV:  full_mv  = v[12:0];
            CFG_EMPTY_MV: empty_mv = v[12:0];
            CFG_SAVE_S:   save_s   = v[11:0];
            default: ;
        endcase
    endfunction

    function longint table_pct(logic [12:0] mv);
        for (int i = 0; i < OCV_ENTRIES; i++)
            if (mv >= OCV_MV[i]) return OCV_PCT[i];
        return 0;
    endfunction

    function void note_sample(t_in s);
        longint cur, mag, nom, tgt, learned, diff;
        longint unsigned n, h, soc;
        longint unsigned dt;
        t_out r;
        cur = s.pack_ma;
        dt = s.elapsed_ms;
        nom = nom_units();
        mag = cur < 0 ? -cur : cur;
        soc = 0;
        r = '0;
        charge -= cur * longint'(dt);
        if (cur < 0) begin
            chg_in += longint'(-cur) * dt;
            n = chg_in / nom;
            chg_in = chg_in % nom;
            cycles = cycles + 16'(n * 10);
        end
        if (mag < longint'(idle_ma)) begin
            rest_ms += dt;
            if (rest_ms >= idle_ms) begin
                tgt = cap_units * table_pct(s.cell_mv) / 100;
                charge += (tgt - charge) / 10;
                rest_ms = idle_ms;
            end
        end else begin
            rest_ms = 0;
        end
        if (s.charger_on && cur < 0 && mag < longint'(full_ma) && s.cell_mv >= full_mv) begin
            if (armed) begin
                learned = charge;
                if (2 * learned > nom && 2 * learned < 3 * nom) begin
                    cap_units = (4 * cap_units + learned) / 5;
                    h = (longint'(cap_units) * 200 + nom) / (2 * nom);
                    health = (h > 100) ? 7'd100 : 7'(h);
                    learns++;
                end
                armed = 0;
            end
            charge = cap_units;
        end
        if (s.cell_mv <= empty_mv && s.cell_mv > 0) begin
            charge = 0;
            armed = 1;
        end
        if (charge < 0) charge = 0;
        if (charge > cap_units) charge = cap_units;
        if (cap_units > 0) begin
            soc = (longint'(charge) * 200 + cap_units) / (2 * cap_units);
            if (soc > 100) soc = 100;
        end
        save_ms += dt;
        if (save_ms >= save_s * 1000) begin
            diff = charge - last_saved;
            save_ms = 0;
            if (diff < 0) diff = -diff;
            if (diff * 100 >= cap_units) begin
                r.save_request = 1'b1;
                last_saved = charge;
                saves++;
            end
        end
        r.charge_pct = 7'(soc);
        r.health_pct = health;
        r.remaining_mah = 17'(longint'(charge) / 3600000);
        r.full_capacity_mah = 17'(longint'(cap_units) / 3600000);
        r.cycle_tenths = cycles;
        pending.push_back(r);
    endfunction

    function void check_result(t_out got);
        t_out e;
        checked++;
        if (pending.size() == 0) begin
            $error("unexpected result transaction %p", got);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.charge_pct !== e.charge_pct) begin
            $error("charge_pct exp %0d got %0d", e.charge_pct, got.charge_pct); errors++;
        end
        if (got.health_pct !== e.health_pct) begin
            $error("health_pct exp %0d got %0d", e.health_pct, got.health_pct); errors++;
        end
        if (got.remaining_mah !== e.remaining_mah) begin
            $error("remaining_mah exp %0d got %0d", e.remaining_mah, got.remaining_mah);
            errors++;
        end
        if (got.full_capacity_mah !== e.full_capacity_mah) begin
            $error("full_capacity_mah exp %0d got %0d", e.full_capacity_mah,
                   got.full_capacity_mah);
            errors++;
        end
        if (got.cycle_tenths !== e.cycle_tenths) begin
            $error("cycle_tenths exp %0d got %0d", e.cycle_tenths, got.cycle_tenths); errors++;
        end
        if (got.save_request !== e.save_request) begin
            $error("save_request exp %0d got %0d", e.save_request, got.save_request); errors++;
        end
    endfunction
endclass

module battery_charge_state_estimator_test;

    localparam int WATCHDOG_CYCLES = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in         in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out        out_data;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = CFG_NOMINAL;
    logic [15:0] cfg_data = '0;

    soc_scoreboard sb;
    int  idle_cycles = 0;
    int  samples_sent = 0;
    bit  hold_off = 1'b0;
    bit  long_stall_req = 1'b0;
    int  stall_mode = 0;

    battery_charge_state_estimator uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall), .i_data(in_data),
        .o_valid(out_valid), .i_stall(out_stall), .o_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // result monitor and watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) sb.check_result(out_data);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (sb.pending.size() == 0 && !in_valid))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // receiver stall pattern, with one long hold-off on request
    always @(negedge clk) begin
        if (long_stall_req) begin
            out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    initial begin
        forever begin
            repeat ($urandom_range(200, 3000)) @(negedge clk);
            stall_mode = $urandom_range(0, 2);
        end
    end

    task automatic write_cfg(logic [2:0] idx, logic [15:0] v);
        @(negedge clk);
        cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, v);
    endtask

    // accept check happens at the next rising edge; drive on falling edges
    task automatic send_sample(t_in s);
        in_valid <= 1'b1;
        in_data <= s;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_sample(s);
        samples_sent++;
        @(negedge clk);
    endtask

    task automatic gap(int n);
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    function automatic t_in mk(int cur, int mv, bit chg, int dt);
        t_in s;
        s.pack_ma = 16'(cur);
        s.cell_mv = 13'(mv);
        s.charger_on = chg;
        s.elapsed_ms = 16'(dt);
        return s;
    endfunction

    function automatic t_in rand_sample();
        t_in s;
        int k;
        k = $urandom_range(0, 9);
        s.charger_on = 1'($urandom_range(0, 1));
        case (k)
            0: s.pack_ma = 16'($urandom);
            1, 2: s.pack_ma = 16'($urandom_range(0, 60));
            3: s.pack_ma = -16'($urandom_range(1, 250));
            4, 5: s.pack_ma = -16'($urandom_range(0, 32768));
            default: s.pack_ma = 16'($urandom_range(0, 32767));
        endcase
        k = $urandom_range(0, 9);
        case (k)
            0: s.cell_mv = 13'($urandom);
            1: s.cell_mv = 13'd0;
            2: s.cell_mv = 13'($urandom_range(2700, 2850));
            3: s.cell_mv = 13'($urandom_range(4100, 4300));
            default: s.cell_mv = 13'($urandom_range(2900, 4200));
        endcase
        k = $urandom_range(0, 5);
        case (k)
            0: s.elapsed_ms = 16'($urandom);
            1: s.elapsed_ms = 16'($urandom_range(0, 10));
            default: s.elapsed_ms = 16'($urandom_range(100, 5000));
        endcase
        return s;
    endfunction

    // discharge to empty then charge to full so learning gets exercised
    task automatic learn_cycle();
        send_sample(mk(1000, 2700, 0, 100));
        for (int i = 0; i < $urandom_range(1, 6); i++)
            send_sample(mk(-32768, 3700 + $urandom_range(0, 400), 1, 65535));
        send_sample(mk(-$urandom_range(1, 150), 4200, 1, $urandom_range(0, 1000)));
    endtask

    task automatic random_phase(int count);
        int burst;
        int k;
        k = 0;
        while (k < count) begin
            burst = $urandom_range(1, 30);
            for (int b = 0; b < burst && k < count; b++) begin
                if ($urandom_range(0, 40) == 0) begin
                    learn_cycle();
                    k += 3;
                end else begin
                    send_sample(rand_sample());
                    k++;
                end
            end
            if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 600));
        end
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed
        send_sample(mk(0, 0, 0, 0));
        send_sample(mk(32767, 8191, 1, 65535));
        send_sample(mk(-32768, 8191, 1, 65535));
        send_sample(mk(-32768, 4000, 1, 65535));
        send_sample(mk(-100, 4150, 1, 100));
        send_sample(mk(10, 0, 0, 40000));
        send_sample(mk(0, 3720, 0, 65535));
        send_sample(mk(-49, 3300, 1, 20000));
        send_sample(mk(500, 2800, 0, 10));
        send_sample(mk(-32768, 3900, 1, 65535));
        send_sample(mk(-32768, 4100, 1, 65535));
        send_sample(mk(-150, 4160, 1, 500));
        send_sample(mk(-1, 4150, 0, 1));
        send_sample(mk(-32768, 2800, 1, 65535));
        send_sample(mk(1, 1, 0, 65535));
        send_sample(mk(16'h5555, 13'h0AAA, 1, 16'hAAAA));
        send_sample(mk(16'hAAAA, 13'h1555, 0, 16'h5555));
        drain();

        // extremes of config
        write_cfg(CFG_NOMINAL, 16'd0);
        write_cfg(CFG_IDLE_MA, 16'd0);
        write_cfg(CFG_IDLE_MS, 16'd0);
        write_cfg(CFG_FULL_MA, 16'd32767);
        write_cfg(CFG_FULL_MV, 16'd0);
        write_cfg(CFG_EMPTY_MV, 16'd8191);
        write_cfg(CFG_SAVE_S, 16'd0);
        random_phase(100);
        drain();

        write_cfg(CFG_NOMINAL, 16'd1000);
        write_cfg(CFG_IDLE_MA, 16'd32767);
        write_cfg(CFG_IDLE_MS, 16'd0);
        write_cfg(CFG_FULL_MA, 16'd300);
        write_cfg(CFG_FULL_MV, 16'd4100);
        write_cfg(CFG_EMPTY_MV, 16'd2850);
        write_cfg(CFG_SAVE_S, 16'd1);
        random_phase(200);

        // long receiver hold-off while samples keep coming
        long_stall_req = 1'b1;
        fork
            begin
                repeat (3000) @(negedge clk);
                long_stall_req = 1'b0;
            end
            for (int i = 0; i < 8; i++) send_sample(rand_sample());
        join
        drain();

        write_cfg(CFG_NOMINAL, 16'd65535);
        write_cfg(CFG_IDLE_MA, 16'd100);
        write_cfg(CFG_IDLE_MS, 16'd65535);
        write_cfg(CFG_FULL_MA, 16'd0);
        write_cfg(CFG_FULL_MV, 16'd8191);
        write_cfg(CFG_EMPTY_MV, 16'd0);
        write_cfg(CFG_SAVE_S, 16'd3600);
        random_phase(150);
        drain();

        write_cfg(CFG_NOMINAL, 16'd20000);
        write_cfg(CFG_IDLE_MA, 16'd50);
        write_cfg(CFG_IDLE_MS, 16'd3000);
        write_cfg(CFG_FULL_MA, 16'd200);
        write_cfg(CFG_FULL_MV, 16'd4150);
        write_cfg(CFG_EMPTY_MV, 16'd2800);
        write_cfg(CFG_SAVE_S, 16'd5);
        random_phase(300);
        drain();

        write_cfg(CFG_NOMINAL, 16'($urandom_range(1000, 65535)));
        write_cfg(CFG_IDLE_MS, 16'($urandom_range(0, 10000)));
        write_cfg(CFG_SAVE_S, 16'($urandom_range(1, 30)));
        random_phase(250);
        drain();

        $display("summary: %0d samples, %0d results checked, %0d save requests, %0d learns",
                 samples_sent, sb.checked, sb.saves, sb.learns);
        $display("covered config extremes, long output hold-off and drained pauses");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
